// ----- design/uks_pkg.sv -----
// Package with the shared constants and types of the unsigned key sorter.
`timescale 1ns / 1ps
`default_nettype none
package uks_pkg;
	localparam int MaxItems = 64;
	localparam int KeyBits = 32;
	localparam int AddrBits = $clog2(MaxItems);
	localparam int CountBits = $clog2(MaxItems + 1);

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_RD_KEY,
		ST_RD_PREV,
		ST_CMP,
		ST_PLACE,
		ST_OUT_RD,
		ST_OUT_WAIT,
		ST_OUT_SEND
	} state_t;
endpackage
`default_nettype wire

// ----- design/uks_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module uks_ram #(
	parameter int Width = 32,
	parameter int Depth = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ----- design/unsigned_key_sorter_unit.sv -----
// Top level of the unsigned key sorter: load, in-place insertion sort, then read-out.
// Loading accepts every word and drops those beyond the store's capacity. After the
// marked word, the insertion sort reads, compares and places each key, with a further
// compare per shifted key (quadratic in the run length n, at most 64); each result is
// then read, registered and held until taken. One comparator and one read port limit
// speed. Reset clears fill count, dropped flag and state; key memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module unsigned_key_sorter_unit
	import uks_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // key[31:0]
	input  wire logic        s_tlast,  // last
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [39:0] m_tdata,  // sorted_key[31:0], overflow[32], zero fill
	output logic             m_tlast   // final_res
);
	state_t state_q, state_d;
	logic [CountBits-1:0] fill_q, fill_d;
	logic                 drop_q, drop_d;
	logic [AddrBits-1:0]  i_q, i_d;
	logic [AddrBits-1:0]  j_q, j_d;
	logic [KeyBits-1:0]   v_q, v_d;
	logic [KeyBits-1:0]   out_key_q, out_key_d;
	logic                 out_last_q, out_last_d;
	logic                 we;
	logic [AddrBits-1:0]  waddr, raddr;
	logic [KeyBits-1:0]   wdata, rdata;
	logic                 greater;

	uks_ram #(.Width(KeyBits), .Depth(MaxItems)) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// The one shared comparator.
	assign greater = rdata > v_q;

	// State and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			fill_q  <= '0;
			drop_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			drop_q  <= drop_d;
		end
	end

	// Working registers.
	always_ff @(posedge clk) begin
		i_q        <= i_d;
		j_q        <= j_d;
		v_q        <= v_d;
		out_key_q  <= out_key_d;
		out_last_q <= out_last_d;
	end

	// Sequencer: next state and datapath control.
	always_comb begin
		state_d    = state_q;
		fill_d     = fill_q;
		drop_d     = drop_q;
		i_d        = i_q;
		j_d        = j_q;
		v_d        = v_q;
		out_key_d  = out_key_q;
		out_last_d = out_last_q;
		we         = 1'b0;
		waddr      = j_q;
		wdata      = v_q;
		raddr      = i_q;
		s_tready   = 1'b0;
		m_tvalid   = 1'b0;
		case (state_q)
			ST_LOAD: begin
				s_tready = 1'b1;
				waddr    = fill_q[AddrBits-1:0];
				wdata    = s_tdata[KeyBits-1:0];
				if (s_tvalid) begin
					if (fill_q < CountBits'(MaxItems)) begin
						we     = 1'b1;
						fill_d = fill_q + 1'b1;
					end else begin
						drop_d = 1'b1;
					end
					if (s_tlast) begin
						i_d     = AddrBits'(1);
						state_d = ST_RD_KEY;
					end
				end
			end
			ST_RD_KEY: begin
				// Key i is read; outer loop ends once i reaches the fill count.
				raddr = i_q;
				if ({1'b0, i_q} >= fill_q || i_q == '0) begin
					i_d     = '0;
					state_d = ST_OUT_RD;
				end else begin
					j_d     = i_q;
					state_d = ST_RD_PREV;
				end
			end
			ST_RD_PREV: begin
				// rdata holds key i here on first entry; later the loop keeps v.
				if (j_q == i_q) begin
					v_d = rdata;
				end
				raddr   = j_q - 1'b1;
				state_d = ST_CMP;
			end
			ST_CMP: begin
				// Shift the previous key up while it exceeds v.
				if (greater) begin
					we    = 1'b1;
					waddr = j_q;
					wdata = rdata;
					j_d   = j_q - 1'b1;
					if (j_q == AddrBits'(1)) begin
						state_d = ST_PLACE;
					end else begin
						raddr   = j_q - AddrBits'(2);
						state_d = ST_CMP;
					end
				end else begin
					state_d = ST_PLACE;
				end
			end
			ST_PLACE: begin
				we    = 1'b1;
				waddr = j_q;
				wdata = v_q;
				raddr = i_q + 1'b1;
				i_d   = i_q + 1'b1;
				if (i_q == AddrBits'(MaxItems - 1)) begin
					i_d     = '0;
					state_d = ST_OUT_RD;
				end else begin
					state_d = ST_RD_KEY;
				end
			end
			ST_OUT_RD: begin
				raddr   = i_q;
				state_d = ST_OUT_WAIT;
			end
			ST_OUT_WAIT: begin
				out_key_d  = rdata;
				out_last_d = ({1'b0, i_q} + 1'b1) == fill_q;
				state_d    = ST_OUT_SEND;
			end
			ST_OUT_SEND: begin
				m_tvalid = 1'b1;
				if (m_tready) begin
					if (out_last_q) begin
						fill_d  = '0;
						drop_d  = 1'b0;
						state_d = ST_LOAD;
					end else begin
						i_d     = i_q + 1'b1;
						state_d = ST_OUT_RD;
					end
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	assign m_tdata = {7'b0, drop_q, out_key_q};
	assign m_tlast = out_last_q;

`ifndef NO_ASSERTIONS
	// The fill count never exceeds the capacity.
	assert property (@(posedge clk) disable iff (!arst_n) fill_q <= CountBits'(MaxItems))
		else $error("fill count above capacity");
	// Input and output are never open at the same time.
	assert property (@(posedge clk) disable iff (!arst_n) !(s_tready && m_tvalid))
		else $error("input and output both active");
	// The final word returns the block to loading with an empty store.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> state_q == ST_LOAD && fill_q == '0)
		else $error("run not cleared after final word");
`endif
endmodule
`default_nettype wire

// ----- dv/unsigned_key_sorter_unit_test.sv -----
// Self-checking testbench for the unsigned key sorter: runs of keys in, sorted words out.
`timescale 1ns / 1ps
`default_nettype none
module unsigned_key_sorter_unit_test;
	import uks_pkg::*;

	typedef struct packed {
		logic [31:0] key;
		logic        last;
	} key_word_t;

	typedef struct packed {
		logic [31:0] sorted_key;
		logic        final_res;
		logic        overflow;
	} sorted_word_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic        m_tlast;

	unsigned_key_sorter_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	key_word_t    pending_keys[$];
	sorted_word_t expected_sorted[$];
	logic [31:0]  run_keys[$];
	logic         run_dropped = 1'b0;
	int           mismatch_count;
	int           words_sent;
	bit           quiet_phase;
	bit           hold_request;
	int           send_gap;
	int           recv_gap;
	int           hold_left;

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Predicts the sorted words for one accepted key word.
	task automatic predict_sort(input key_word_t w);
		logic [31:0] v;
		int          j;
		begin
			if (run_keys.size() < MaxItems)
				run_keys.push_back(w.key);
			else
				run_dropped = 1'b1;
			if (w.last) begin
				for (int i = 1; i < run_keys.size(); i++) begin
					v = run_keys[i];
					j = i;
					while (j > 0 && run_keys[j - 1] > v) begin
						run_keys[j] = run_keys[j - 1];
						j--;
					end
					run_keys[j] = v;
				end
				foreach (run_keys[i])
					expected_sorted.push_back('{run_keys[i], i == run_keys.size() - 1,
						run_dropped});
				run_keys.delete();
				run_dropped = 1'b0;
			end
		end
	endtask

	task automatic queue_run(input int n, input bit extreme);
		key_word_t w;
		begin
			for (int i = 0; i < n; i++) begin
				case (extreme ? $urandom_range(0, 3) : 3)
					0: w.key = 32'h0;
					1: w.key = 32'hFFFF_FFFF;
					2: w.key = 32'h8000_0000 | $urandom_range(0, 3);
					default: w.key = $urandom();
				endcase
				if ($urandom_range(0, 7) == 0 && i > 0)
					w.key = pending_keys[pending_keys.size() - 1].key;
				w.last = (i == n - 1);
				pending_keys.push_back(w);
			end
		end
	endtask

	// Driver: offers queued words with random bursts of idling.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid   <= 1'b0;
			s_tdata    <= '0;
			s_tlast    <= 1'b0;
			send_gap   <= 0;
			words_sent <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_sort('{s_tdata, s_tlast});
				words_sent <= words_sent + 1;
			end
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					s_tvalid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (pending_keys.size() > 0) begin
					key_word_t w;
					w = pending_keys.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= w.key;
					s_tlast  <= w.last;
					if (!quiet_phase && $urandom_range(0, 5) == 0)
						send_gap <= $urandom_range(1, 9);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random back-pressure plus one long hold-off on request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready  <= 1'b0;
			recv_gap  <= 0;
			hold_left <= 0;
		end else if (hold_request && hold_left == 0) begin
			hold_left <= 400;
			m_tready  <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= (hold_left == 1);
		end else if (recv_gap > 0) begin
			recv_gap <= recv_gap - 1;
			m_tready <= (recv_gap == 1);
		end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
			recv_gap <= $urandom_range(1, 9);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Monitor: compares each accepted sorted word with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sorted_word_t got;
			sorted_word_t want;
			got = '{m_tdata[31:0], m_tlast, m_tdata[32]};
			if (expected_sorted.size() == 0) begin
				if (mismatch_count < 10)
					$display("unexpected word: key %h last %b ovf %b",
						got.sorted_key, got.final_res, got.overflow);
				mismatch_count++;
			end else begin
				want = expected_sorted.pop_front();
				if (got !== want || m_tdata[39:33] !== '0) begin
					if (mismatch_count < 10)
						$display("mismatch: expected key %h last %b ovf %b, got %h %b %b",
							want.sorted_key, want.final_res, want.overflow,
							got.sorted_key, got.final_res, got.overflow);
					mismatch_count++;
				end
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		int wait_cycles;
		arst_n = 1'b0;
		quiet_phase = 1'b0;
		hold_request = 1'b0;
		// Directed runs: single key, extremes, duplicates, a full store and an overflow.
		pending_keys.push_back('{32'h0, 1'b1});
		pending_keys.push_back('{32'hFFFF_FFFF, 1'b1});
		pending_keys.push_back('{32'hFFFF_FFFF, 1'b0});
		pending_keys.push_back('{32'h0, 1'b0});
		pending_keys.push_back('{32'h8000_0000, 1'b0});
		pending_keys.push_back('{32'h7FFF_FFFF, 1'b0});
		pending_keys.push_back('{32'h0, 1'b1});
		queue_run(MaxItems, 1'b1);
		queue_run(MaxItems + 3, 1'b1);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		// Random runs, mostly short, with a long receiver hold-off part way through.
		while (pending_keys.size() < 350)
			queue_run(($urandom_range(0, 9) == 0) ? $urandom_range(40, 70)
				: $urandom_range(1, 8), $urandom_range(0, 1));
		wait (words_sent > 160);
		hold_request = 1'b1;
		wait (hold_left > 0);
		hold_request = 1'b0;
		wait (words_sent > 330);
		quiet_phase = 1'b1;
		wait (pending_keys.size() == 0 && !s_tvalid);
		wait (expected_sorted.size() == 0);
		wait_cycles = 0;
		while (wait_cycles < 200) begin
			@(posedge clk);
			wait_cycles++;
		end
		if (mismatch_count == 0 && expected_sorted.size() == 0 && run_keys.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Watchdog.
	initial begin
		#20ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
`default_nettype wire
